### rtl/core/dcsc_pkg.sv
package dcsc_pkg;

   localparam int NUM_COLORS  = 4;
   localparam int COLOR_IDX_W = 2;
   localparam int CODE_W      = 3;
   localparam int HIT_W       = 8;
   localparam int MISS_W      = 4;
   localparam int SEG_W       = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [COLOR_IDX_W-1:0] GREEN_IDX = 2'd0;
   localparam logic [COLOR_IDX_W-1:0] BLUE_IDX  = 2'd3;

   localparam logic [HIT_W-1:0]  HIT_MAX  = 8'hFF;
   localparam logic [MISS_W-1:0] MISS_MAX = 4'hF;
   localparam logic [SEG_W-1:0]  SEG_MAX  = 8'hFF;

   localparam logic [7:0] HIT_THRESHOLD_RST      = 8'd6;
   localparam logic [7:0] BLUE_HIT_THRESHOLD_RST = 8'd5;
   localparam logic [3:0] MISS_LIMIT_RST         = 4'd3;
   localparam logic [7:0] TARGET_COUNT_RST       = 8'd7;

   // Sensor codes
   typedef enum logic [CODE_W-1:0] {
      CODE_NONE   = 3'd0,
      CODE_GREEN  = 3'd1,
      CODE_RED    = 3'd2,
      CODE_YELLOW = 3'd3,
      CODE_BLUE   = 3'd4
   } color_code_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_HIT_THRESHOLD      = 2'd0,
      CSR_BLUE_HIT_THRESHOLD = 2'd1,
      CSR_MISS_LIMIT         = 2'd2,
      CSR_TARGET_COUNT       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] hit_threshold;
      logic [7:0] blue_hit_threshold;
      logic [3:0] miss_limit;
      logic [7:0] target_count;
   } config_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][HIT_W-1:0]  hit_counts;
      logic [NUM_COLORS-1:0][MISS_W-1:0] miss_counts;
      logic [NUM_COLORS-1:0]             latched_flags;
      logic [SEG_W-1:0]                  green_segments;
   } color_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] confirmed_color;
      logic [SEG_W-1:0]  segment_count;
      logic              done_res;
   } result_type;

endpackage

### rtl/core/dcsc_update.sv
// Next-state and result logic for one sensor sample.
module dcsc_update
   import dcsc_pkg::*;
(
   input  logic [CODE_W-1:0] color_code,
   input  config_type        cfg,
   input  color_state_type   state_cur,
   output color_state_type   state_nxt,
   output result_type        result
);

   logic                   sel_valid;
   logic [COLOR_IDX_W-1:0] sel_idx;
   logic [7:0]             threshold;
   logic                   confirm;

   always_comb begin
      sel_valid = color_code inside {CODE_GREEN, CODE_RED, CODE_YELLOW, CODE_BLUE};
      sel_idx   = COLOR_IDX_W'(color_code - CODE_GREEN);
      threshold = (sel_idx == BLUE_IDX) ? cfg.blue_hit_threshold : cfg.hit_threshold;
      confirm   = sel_valid && (state_cur.hit_counts[sel_idx] >= threshold)
                  && !state_cur.latched_flags[sel_idx];
   end

   always_comb begin
      state_nxt = state_cur;

      // confirmation: latch the sampled color, drop all others
      if (confirm) begin
         for (int j = 0; j < NUM_COLORS; j++) begin
            if (COLOR_IDX_W'(j) != sel_idx) begin
               state_nxt.latched_flags[j] = 1'b0;
               state_nxt.hit_counts[j]    = '0;
            end
         end
         state_nxt.latched_flags[sel_idx] = 1'b1;
         state_nxt.miss_counts[sel_idx]   = '0;
         if (sel_idx == GREEN_IDX && state_cur.green_segments != SEG_MAX) begin
            state_nxt.green_segments = state_cur.green_segments + 1'b1;
         end
      end

      if (sel_valid && state_cur.hit_counts[sel_idx] != HIT_MAX) begin
         state_nxt.hit_counts[sel_idx] = state_cur.hit_counts[sel_idx] + 1'b1;
      end

      // miss bookkeeping for every color not sampled
      for (int j = 0; j < NUM_COLORS; j++) begin
         if (!(sel_valid && COLOR_IDX_W'(j) == sel_idx)) begin
            if (state_cur.miss_counts[j] >= cfg.miss_limit) begin
               state_nxt.hit_counts[j] = '0;
            end else if (state_cur.miss_counts[j] != MISS_MAX) begin
               state_nxt.miss_counts[j] = state_cur.miss_counts[j] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.confirmed_color = '0;
      for (int j = NUM_COLORS - 1; j >= 0; j--) begin
         if (state_nxt.latched_flags[j]) begin
            result.confirmed_color = CODE_W'(j + 1);
         end
      end
      result.segment_count = state_nxt.green_segments;
      result.done_res      = (state_nxt.green_segments >= cfg.target_count);
   end

endmodule

### rtl/core/debounced_color_segment_counter_core.sv
// A request is held in the input register, then in the result register, before the response
// is valid; the color state updates as a request leaves the input register.
// Throughput: one request per cycle while the response side is not stalled.
// A stalled response holds the result register; the input register keeps taking requests until full.
// Reset (synchronous, active high) clears all hit, miss, latch and segment state,
// empties both registers and loads the configuration registers with their defaults.
module debounced_color_segment_counter_core
   import dcsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CODE_W-1:0]     req_color_code,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CODE_W-1:0]     rsp_confirmed_color,
   output logic [SEG_W-1:0]      rsp_segment_count,
   output logic                  rsp_done_res,

   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // Configuration registers
   config_type cfg_ff, cfg_in;

   // Input register: one request waiting for the update logic
   logic              s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0] s1_code_ff;

   // Per-color debounce state
   color_state_type state_ff, state_nxt;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, result;

   logic rsp_free;
   logic s1_advance;
   logic req_accept;

   // The result register is free when empty or being drained this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && rsp_free;
   // Hold the request side only while the input register is full and cannot move on.
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HIT_THRESHOLD:      cfg_in.hit_threshold      = csr_write_data;
            CSR_BLUE_HIT_THRESHOLD: cfg_in.blue_hit_threshold = csr_write_data;
            CSR_MISS_LIMIT:         cfg_in.miss_limit         = csr_write_data[3:0];
            CSR_TARGET_COUNT:       cfg_in.target_count       = csr_write_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      // Input register fills on accept, drains when it moves into the result register.
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
      // Result register loads on advance, drops once the response is taken.
      rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);
   end

   dcsc_update u_update (
      .color_code (s1_code_ff),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_nxt),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_threshold      <= HIT_THRESHOLD_RST;
         cfg_ff.blue_hit_threshold <= BLUE_HIT_THRESHOLD_RST;
         cfg_ff.miss_limit         <= MISS_LIMIT_RST;
         cfg_ff.target_count       <= TARGET_COUNT_RST;
         s1_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         state_ff                  <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Advance the color state exactly once per request.
         if (s1_advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_code_ff <= req_color_code;
      end
      if (s1_advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_confirmed_color = rsp_data_ff.confirmed_color;
   assign rsp_segment_count   = rsp_data_ff.segment_count;
   assign rsp_done_res        = rsp_data_ff.done_res;

`ifndef SYNTHESIS
   // At most one color may be latched at any time.
   a_single_latch: assert property (@(posedge clock) disable iff (reset)
      $onehot0(state_ff.latched_flags))
      else $error("more than one color latched");

   // Color state changes only when a request moves through the update logic.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(state_ff))
      else $error("color state changed without a request");

   // An advancing request always shows up as a response in the next cycle.
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced request produced no response");

   // The segment count never goes backwards outside of reset.
   a_seg_monotonic: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> state_ff.green_segments >= $past(state_ff.green_segments))
      else $error("segment count decreased");
`endif

endmodule

### test/tb_debounced_color_segment_counter_core.sv
module tb_debounced_color_segment_counter_core;
   import dcsc_pkg::*;

   // Run length guard: roughly 760 requests, each allowed a long sender gap, a
   // long receiver stall and the pipeline latency, taken several times over.
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [CODE_W-1:0]     req_color_code   = CODE_NONE;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [CODE_W-1:0]     rsp_confirmed_color;
   logic [SEG_W-1:0]      rsp_segment_count;
   logic                  rsp_done_res;
   logic                  csr_write_enable = 1'b0;
   logic [1:0]            csr_index        = CSR_HIT_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   debounced_color_segment_counter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_color_code      (req_color_code),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_confirmed_color (rsp_confirmed_color),
      .rsp_segment_count   (rsp_segment_count),
      .rsp_done_res        (rsp_done_res),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Sensor codes waiting to be sent, and the readings predicted for requests
   // already taken by the block, oldest first.
   logic [CODE_W-1:0] sensor_samples[$];
   result_type        predicted_readings[$];

   // Shadow copy of the color tracking state and the configuration registers.
   logic [HIT_W-1:0]  hits     [NUM_COLORS];
   logic [MISS_W-1:0] misses   [NUM_COLORS];
   logic              latched  [NUM_COLORS];
   logic [SEG_W-1:0]  segments;
   logic [7:0]        cfg_hit_threshold      = HIT_THRESHOLD_RST;
   logic [7:0]        cfg_blue_hit_threshold = BLUE_HIT_THRESHOLD_RST;
   logic [3:0]        cfg_miss_limit         = MISS_LIMIT_RST;
   logic [7:0]        cfg_target_count       = TARGET_COUNT_RST;

   int  failures         = 0;
   int  readings_checked = 0;
   int  green_confirms   = 0;
   int  settings_used    = 1;
   int  cycle_count      = 0;
   bit  steady_flow      = 1'b0;   // both sides run without gaps or stalls
   int  gap_left         = 0;
   int  stall_left       = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the shadow state by one sensor sample and queue the reading it yields.
   function automatic void predict_sample(logic [CODE_W-1:0] code);
      int               sel;
      int               j;
      logic [HIT_W-1:0] thr;
      result_type       reading;
      sel = (code >= CODE_GREEN && code <= CODE_BLUE) ? int'(code) - 1 : -1;
      if (sel >= 0) begin
         thr = (sel == BLUE_IDX) ? cfg_blue_hit_threshold : cfg_hit_threshold;
         // Confirm on reaching the threshold, but only on the first time in a row.
         if (hits[sel] >= thr && !latched[sel]) begin
            for (j = 0; j < NUM_COLORS; j++) begin
               if (j != sel) begin
                  latched[j] = 1'b0;
                  hits[j]    = '0;
               end
            end
            latched[sel] = 1'b1;
            misses[sel]  = '0;
            if (sel == GREEN_IDX) begin
               green_confirms++;
               if (segments < SEG_MAX) segments++;
            end
         end
         if (hits[sel] < HIT_MAX) hits[sel]++;
      end
      // Every other color counts a miss, or drops its hits once at the limit.
      for (j = 0; j < NUM_COLORS; j++) begin
         if (j != sel) begin
            if (misses[j] >= cfg_miss_limit) hits[j] = '0;
            else if (misses[j] < MISS_MAX) misses[j]++;
         end
      end
      reading.confirmed_color = CODE_NONE;
      for (j = NUM_COLORS - 1; j >= 0; j--) begin
         if (latched[j]) reading.confirmed_color = CODE_W'(j + 1);
      end
      reading.segment_count = segments;
      reading.done_res      = (segments >= cfg_target_count);
      predicted_readings.push_back(reading);
   endfunction

   // Mostly back to back, sometimes a short pause, rarely a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Request driver: predict on each accepted request, then present the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) predict_sample(req_color_code);
         // Hold a stalled request; otherwise advance to the next slot.
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sensor_samples.size() > 0) begin
               req_valid      <= 1'b1;
               req_color_code <= sensor_samples.pop_front();
               gap_left       = pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each accepted reading with the oldest prediction,
   // then choose the stall for the next cycle.
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_readings.size() == 0) begin
               $error("reading arrived with no request outstanding: color %0d count %0d done %0d",
                      rsp_confirmed_color, rsp_segment_count, rsp_done_res);
               failures++;
            end else begin
               want = predicted_readings.pop_front();
               readings_checked++;
               if (rsp_confirmed_color !== want.confirmed_color) begin
                  $error("confirmed_color: expected %0d, got %0d",
                         want.confirmed_color, rsp_confirmed_color);
                  failures++;
               end
               if (rsp_segment_count !== want.segment_count) begin
                  $error("segment_count: expected %0d, got %0d",
                         want.segment_count, rsp_segment_count);
                  failures++;
               end
               if (rsp_done_res !== want.done_res) begin
                  $error("done_res: expected %0d, got %0d", want.done_res, rsp_done_res);
                  failures++;
               end
            end
         end
         if (steady_flow) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_pause();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_debounced_color_segment_counter_core: FAIL");
         $finish;
      end
   end

   // Write one register and mirror it in the shadow configuration.
   task automatic write_register(csr_index_type idx, logic [7:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_HIT_THRESHOLD:      cfg_hit_threshold      = data;
         CSR_BLUE_HIT_THRESHOLD: cfg_blue_hit_threshold = data;
         CSR_MISS_LIMIT:         cfg_miss_limit         = data[3:0];
         CSR_TARGET_COUNT:       cfg_target_count       = data;
         default:                cfg_hit_threshold      = cfg_hit_threshold;
      endcase
   endtask

   task automatic apply_settings(logic [7:0] thr, logic [7:0] blue_thr,
                                 logic [3:0] limit, logic [7:0] target);
      write_register(CSR_HIT_THRESHOLD, thr);
      write_register(CSR_BLUE_HIT_THRESHOLD, blue_thr);
      write_register(CSR_MISS_LIMIT, {4'd0, limit});
      write_register(CSR_TARGET_COUNT, target);
      settings_used++;
   endtask

   // Drain: nothing left to send, nothing in flight, then a few quiet cycles.
   task automatic wait_idle();
      do @(negedge clock);
      while (sensor_samples.size() > 0 || req_valid || predicted_readings.size() > 0);
      repeat (6) @(negedge clock);
   endtask

   // Queue runs of one color, sized around its threshold so that confirmations
   // happen often, mixed with runs of noise that build up misses.
   task automatic queue_color_runs(int count);
      int          queued;
      int          len;
      int          thr;
      logic [CODE_W-1:0] code;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            code = CODE_W'($urandom_range(int'(CODE_GREEN), int'(CODE_BLUE)));
            thr  = (code == CODE_BLUE) ? int'(cfg_blue_hit_threshold)
                                       : int'(cfg_hit_threshold);
            if (thr > 20 && $urandom_range(0, 3) == 0) len = thr + $urandom_range(1, 4);
            else len = $urandom_range(1, (thr > 20 ? 20 : thr) + 3);
            repeat (len) sensor_samples.push_back(code);
         end else begin
            len = $urandom_range(1, int'(cfg_miss_limit) + 2);
            repeat (len) sensor_samples.push_back(CODE_W'($urandom_range(0, 2**CODE_W - 1)));
         end
         queued += len;
      end
   endtask

   initial begin
      int k;
      for (k = 0; k < NUM_COLORS; k++) begin
         hits[k]    = '0;
         misses[k]  = '0;
         latched[k] = 1'b0;
      end
      segments = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults first, no register writes.
      queue_color_runs(30);
      wait_idle();

      // Directed: unused codes, each color confirmed in turn, blue clearing
      // the others, green confirmed again and then held without recounting.
      apply_settings(8'd1, 8'd1, 4'd15, 8'd1);
      for (k = int'(CODE_BLUE) + 1; k < 2**CODE_W; k++) sensor_samples.push_back(k[CODE_W-1:0]);
      sensor_samples.push_back(CODE_NONE);
      repeat (2) sensor_samples.push_back(CODE_GREEN);
      repeat (2) sensor_samples.push_back(CODE_RED);
      repeat (2) sensor_samples.push_back(CODE_YELLOW);
      repeat (2) sensor_samples.push_back(CODE_BLUE);
      repeat (3) sensor_samples.push_back(CODE_GREEN);
      sensor_samples.push_back(CODE_BLUE);
      sensor_samples.push_back(CODE_NONE);
      wait_idle();

      apply_settings(8'd3, 8'd2, 4'd2, 8'd4);
      queue_color_runs(30);
      wait_idle();

      // High thresholds and the widest miss limit: long runs needed to confirm.
      apply_settings(8'd30, 8'd25, 4'd15, 8'd255);
      queue_color_runs(50);
      wait_idle();

      // Drop the miss limit below counts built up before.
      apply_settings(8'd2, 8'd4, 4'd1, 8'd200);
      queue_color_runs(30);
      wait_idle();

      steady_flow = 1'b1;
      apply_settings(8'($urandom_range(1, 40)), 8'($urandom_range(1, 12)),
                     4'($urandom_range(1, 15)), 8'($urandom_range(1, 255)));
      queue_color_runs(30);
      wait_idle();
      steady_flow = 1'b0;

      // Zero thresholds, zero miss limit and zero target: every first hit
      // confirms, so alternate green with another color to run the segment
      // count into saturation and hold it there.
      apply_settings(8'd0, 8'd0, 4'd0, 8'd0);
      sensor_samples.push_back(CODE_RED);
      repeat (256) begin
         sensor_samples.push_back(CODE_GREEN);
         sensor_samples.push_back(CODE_W'($urandom_range(int'(CODE_RED), int'(CODE_BLUE))));
      end
      wait_idle();

      apply_settings(8'd6, 8'd5, 4'd3, 8'd255);
      queue_color_runs(20);
      wait_idle();

      $display("Checked %0d sensor readings under %0d register settings;",
               readings_checked, settings_used);
      $display("%0d green confirmations, final segment count %0d.", green_confirms, segments);
      if (failures == 0) begin
         $display("tb_debounced_color_segment_counter_core: PASS");
      end else begin
         $display("tb_debounced_color_segment_counter_core: FAIL");
      end
      $finish;
   end

endmodule
